// ----- rtl/row_value_tlv_deserializer_assert.svh -----
// Assertion macros for the deserializer RTL files; rvtd_queue is the only file that includes it.
// Depends on nothing; files that check their own logic include it by name.
`ifndef ROW_VALUE_TLV_DESERIALIZER_ASSERT_SVH
`define ROW_VALUE_TLV_DESERIALIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RVTD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RVTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/rvtd_pkg.sv -----
// Types and codes for the row/value TLV deserializer.
// No dependencies; every other RTL file but the assertion header refers to it by scoped names.
`timescale 1ns / 1ps

package rvtd_pkg;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_COUNT    = 3'd1,
      PH_TAG      = 3'd2,
      PH_PAYLOAD  = 3'd3,
      PH_STRING   = 3'd4,
      PH_COMPLETE = 3'd5,
      PH_DISCARD  = 3'd6
   } phase_type;

   localparam logic [2:0] KIND_INT       = 3'd0;
   localparam logic [2:0] KIND_DOUBLE    = 3'd1;
   localparam logic [2:0] KIND_STR_HDR   = 3'd2;
   localparam logic [2:0] KIND_STR_BYTE  = 3'd3;
   localparam logic [2:0] KIND_DONE      = 3'd4;
   localparam logic [2:0] KIND_ERROR     = 3'd5;

   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_UNEXP_END  = 2'd1;
   localparam logic [1:0] ERR_BAD_TAG    = 2'd2;
   localparam logic [1:0] ERR_TRAILING   = 2'd3;

   localparam logic [1:0] TAG_INT        = 2'd1;
   localparam logic [1:0] TAG_DOUBLE     = 2'd2;
   localparam logic [1:0] TAG_VARCHAR    = 2'd3;

   localparam logic [31:0] COUNT_BYTES   = 32'd4;
   localparam logic [3:0]  LEN_BYTES     = 4'd4;
   localparam logic [3:0]  WORD_BYTES    = 4'd8;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        frame_start;
      logic        frame_last;
      logic [31:0] frame_length;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [63:0] value_out;
      logic [1:0]  error_code;
      logic [31:0] error_offset;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      rsp_type first;
      rsp_type second;
      logic    pair;
   } entry_type;

endpackage

// ----- rtl/rvtd_front.sv -----
// Front end: holds the parse state, decodes one byte per beat and builds queue entries.
// Depends on rvtd_pkg.
`timescale 1ns / 1ps

module rvtd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  rvtd_pkg::req_type   req_data,
   input  logic                q_full,
   input  logic                csr_valid,
   input  logic                csr_row_mode,
   output logic                q_push,
   output rvtd_pkg::entry_type q_entry
);

   rvtd_pkg::phase_type phase_ff, phase_in, phase_step, cur_phase;
   logic        row_mode_ff, row_mode_in;
   logic [31:0] offset_ff, offset_in, cur_offset;
   logic [31:0] fstart_ff, fstart_in, cur_fstart;
   logic [63:0] acc_ff, acc_in, cur_acc, acc_ins;
   logic [2:0]  idx_ff, idx_in, cur_idx;
   logic [1:0]  tag_ff, tag_in, cur_tag;
   logic [31:0] vleft_ff, vleft_in, cur_vleft, vleft_dec;
   logic [31:0] sleft_ff, sleft_in, cur_sleft, sleft_dec;
   logic [31:0] rows_ff, rows_in, cur_rows;
   logic [31:0] blen_ff, blen_in, cur_blen;

   logic        accept, active, step;
   logic [7:0]  b;
   logic [3:0]  idx_inc, need;
   logic [31:0] field_word, rem, offset_next;
   logic        count_full, count_over, tag_ok, field_full, len_zero;
   logic        str_done, vals_done;
   logic        sw_valid, end_valid;
   rvtd_pkg::rsp_type sw_res, end_res;

   // Effective state: a start byte restarts the parse before it is decoded.
   always_comb begin
      b      = req_data.data_byte;
      accept = req_push && !q_full;
      active = req_data.frame_start || (phase_ff != rvtd_pkg::PH_IDLE);
      step   = accept && active;
      if (req_data.frame_start) begin
         cur_phase  = row_mode_ff ? rvtd_pkg::PH_COUNT : rvtd_pkg::PH_TAG;
         cur_offset = '0;
         cur_fstart = '0;
         cur_acc    = '0;
         cur_idx    = '0;
         cur_tag    = '0;
         cur_vleft  = row_mode_ff ? 32'd0 : 32'd1;
         cur_sleft  = '0;
         cur_rows   = '0;
         cur_blen   = req_data.frame_length;
      end else begin
         cur_phase  = phase_ff;
         cur_offset = offset_ff;
         cur_fstart = fstart_ff;
         cur_acc    = acc_ff;
         cur_idx    = idx_ff;
         cur_tag    = tag_ff;
         cur_vleft  = vleft_ff;
         cur_sleft  = sleft_ff;
         cur_rows   = rows_ff;
         cur_blen   = blen_ff;
      end
      acc_ins     = cur_acc | ({56'd0, b} << {cur_idx, 3'b000});
      idx_inc     = {1'b0, cur_idx} + 4'd1;
      field_word  = acc_ins[31:0];
      count_full  = idx_inc == rvtd_pkg::LEN_BYTES;
      rem         = (cur_blen >= rvtd_pkg::COUNT_BYTES) ? cur_blen - rvtd_pkg::COUNT_BYTES : 32'd0;
      count_over  = field_word > rem;
      tag_ok      = (b == {6'd0, rvtd_pkg::TAG_INT}) || (b == {6'd0, rvtd_pkg::TAG_DOUBLE}) ||
                    (b == {6'd0, rvtd_pkg::TAG_VARCHAR});
      need        = (cur_tag == rvtd_pkg::TAG_VARCHAR) ? rvtd_pkg::LEN_BYTES : rvtd_pkg::WORD_BYTES;
      field_full  = idx_inc >= need;
      len_zero    = field_word == 32'd0;
      sleft_dec   = cur_sleft - 32'd1;
      str_done    = sleft_dec == 32'd0;
      vleft_dec   = cur_vleft - 32'd1;
      vals_done   = vleft_dec == 32'd0;
      offset_next = cur_offset + 32'd1;
   end

   // Next state.
   always_comb begin
      phase_step  = phase_ff;
      offset_in   = offset_ff;
      fstart_in   = fstart_ff;
      acc_in      = acc_ff;
      idx_in      = idx_ff;
      tag_in      = tag_ff;
      vleft_in    = vleft_ff;
      sleft_in    = sleft_ff;
      rows_in     = rows_ff;
      blen_in     = blen_ff;
      row_mode_in = csr_valid ? csr_row_mode : row_mode_ff;
      if (step) begin
         phase_step = cur_phase;
         offset_in  = offset_next;
         fstart_in  = cur_fstart;
         acc_in     = cur_acc;
         idx_in     = cur_idx;
         tag_in     = cur_tag;
         vleft_in   = cur_vleft;
         sleft_in   = cur_sleft;
         rows_in    = cur_rows;
         blen_in    = cur_blen;
         unique case (cur_phase)
            rvtd_pkg::PH_COUNT: begin
               acc_in = acc_ins;
               idx_in = idx_inc[2:0];
               if (count_full) begin
                  rows_in  = field_word;
                  vleft_in = field_word;
                  if (count_over) begin
                     phase_step = rvtd_pkg::PH_DISCARD;
                  end else if (len_zero) begin
                     phase_step = rvtd_pkg::PH_COMPLETE;
                  end else begin
                     phase_step = rvtd_pkg::PH_TAG;
                     fstart_in  = offset_next;
                  end
               end
            end
            rvtd_pkg::PH_TAG: begin
               if (tag_ok) begin
                  tag_in     = b[1:0];
                  phase_step = rvtd_pkg::PH_PAYLOAD;
                  fstart_in  = offset_next;
                  acc_in     = '0;
                  idx_in     = '0;
               end else begin
                  phase_step = rvtd_pkg::PH_DISCARD;
               end
            end
            rvtd_pkg::PH_PAYLOAD: begin
               acc_in = acc_ins;
               idx_in = idx_inc[2:0];
               if (field_full) begin
                  idx_in = '0;
                  if ((cur_tag == rvtd_pkg::TAG_VARCHAR) && !len_zero) begin
                     sleft_in   = field_word;
                     phase_step = rvtd_pkg::PH_STRING;
                     fstart_in  = offset_next;
                  end else begin
                     vleft_in = vleft_dec;
                     if (vals_done) begin
                        phase_step = rvtd_pkg::PH_COMPLETE;
                     end else begin
                        phase_step = rvtd_pkg::PH_TAG;
                        fstart_in  = offset_next;
                     end
                  end
               end
            end
            rvtd_pkg::PH_STRING: begin
               sleft_in = sleft_dec;
               if (str_done) begin
                  vleft_in = vleft_dec;
                  if (vals_done) begin
                     phase_step = rvtd_pkg::PH_COMPLETE;
                  end else begin
                     phase_step = rvtd_pkg::PH_TAG;
                     fstart_in  = offset_next;
                  end
               end
            end
            rvtd_pkg::PH_COMPLETE: begin
               phase_step = rvtd_pkg::PH_DISCARD;
            end
            default: begin
               phase_step = cur_phase;
            end
         endcase
      end
      phase_in = (step && req_data.frame_last) ? rvtd_pkg::PH_IDLE : phase_step;
   end

   // Results of the beat.
   always_comb begin
      sw_valid            = 1'b0;
      sw_res.kind         = rvtd_pkg::KIND_ERROR;
      sw_res.value_out    = '0;
      sw_res.error_code   = rvtd_pkg::ERR_NONE;
      sw_res.error_offset = '0;
      sw_res.last_of_run  = 1'b0;
      unique case (cur_phase)
         rvtd_pkg::PH_COUNT: begin
            if (count_full && count_over) begin
               sw_valid            = 1'b1;
               sw_res.error_code   = rvtd_pkg::ERR_UNEXP_END;
               sw_res.error_offset = rvtd_pkg::COUNT_BYTES;
            end
         end
         rvtd_pkg::PH_TAG: begin
            if (!tag_ok) begin
               sw_valid            = 1'b1;
               sw_res.error_code   = rvtd_pkg::ERR_BAD_TAG;
               sw_res.error_offset = cur_offset;
            end
         end
         rvtd_pkg::PH_PAYLOAD: begin
            if (field_full) begin
               sw_valid = 1'b1;
               if (cur_tag == rvtd_pkg::TAG_VARCHAR) begin
                  sw_res.kind      = rvtd_pkg::KIND_STR_HDR;
                  sw_res.value_out = {32'd0, field_word};
               end else begin
                  sw_res.kind      = (cur_tag == rvtd_pkg::TAG_INT) ? rvtd_pkg::KIND_INT
                                                                    : rvtd_pkg::KIND_DOUBLE;
                  sw_res.value_out = acc_ins;
               end
            end
         end
         rvtd_pkg::PH_STRING: begin
            sw_valid         = 1'b1;
            sw_res.kind      = rvtd_pkg::KIND_STR_BYTE;
            sw_res.value_out = {56'd0, b};
         end
         rvtd_pkg::PH_COMPLETE: begin
            sw_valid            = 1'b1;
            sw_res.error_code   = rvtd_pkg::ERR_TRAILING;
            sw_res.error_offset = cur_offset;
         end
         default: begin
            sw_valid = 1'b0;
         end
      endcase

      end_valid            = req_data.frame_last && (phase_step != rvtd_pkg::PH_DISCARD);
      end_res.value_out    = '0;
      end_res.last_of_run  = 1'b1;
      if (phase_step == rvtd_pkg::PH_COMPLETE) begin
         end_res.kind         = rvtd_pkg::KIND_DONE;
         end_res.error_code   = rvtd_pkg::ERR_NONE;
         end_res.error_offset = '0;
         if (row_mode_ff) begin
            end_res.value_out = {32'd0, rows_in};
         end
      end else begin
         end_res.kind         = rvtd_pkg::KIND_ERROR;
         end_res.error_code   = rvtd_pkg::ERR_UNEXP_END;
         end_res.error_offset = fstart_in;
      end

      q_push       = step && (sw_valid || end_valid);
      q_entry.pair = sw_valid && end_valid;
      q_entry.first = sw_valid ? sw_res : end_res;
      q_entry.first.last_of_run = !(sw_valid && end_valid);
      q_entry.second = end_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= rvtd_pkg::PH_IDLE;
         row_mode_ff <= 1'b1;
      end else begin
         phase_ff    <= phase_in;
         row_mode_ff <= row_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
      fstart_ff <= fstart_in;
      acc_ff    <= acc_in;
      idx_ff    <= idx_in;
      tag_ff    <= tag_in;
      vleft_ff  <= vleft_in;
      sleft_ff  <= sleft_in;
      rows_ff   <= rows_in;
      blen_ff   <= blen_in;
   end

endmodule

// ----- rtl/rvtd_queue.sv -----
// Short queue of result entries between the parser front end and the output stage.
// Depends on rvtd_pkg and row_value_tlv_deserializer_assert.svh.
`timescale 1ns / 1ps
`include "row_value_tlv_deserializer_assert.svh"

module rvtd_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rvtd_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output rvtd_pkg::entry_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rvtd_pkg::entry_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      full    = count_ff == CNT_W'(DEPTH);
      empty   = count_ff == '0;
      do_push = push && !full;
      do_pop  = pop && !empty;
      head    = slots_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `RVTD_ASSERT_SAME(a_no_push_full, clock, reset, push, !full, "push while queue full")
   `RVTD_ASSERT_SAME(a_no_pop_empty, clock, reset, pop, !empty, "pop while queue empty")
   `RVTD_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH), "count overflow")
   `RVTD_ASSERT_NEXT(a_push_fills, clock, reset, push && !pop, !empty, "pushed entry lost")

endmodule

// ----- rtl/rvtd_back.sv -----
// Back end: splits queue entries into single results and holds the result register.
// Depends on rvtd_pkg.
`timescale 1ns / 1ps

module rvtd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  rvtd_pkg::entry_type q_head,
   output logic                q_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output rvtd_pkg::rsp_type   rsp_data
);

   logic              sel_ff, sel_in;
   logic              valid_ff, valid_in;
   rvtd_pkg::rsp_type out_ff, out_in;
   logic              load, last_part;

   always_comb begin
      load      = !q_empty && (!valid_ff || rsp_pop);
      last_part = !q_head.pair || sel_ff;
      q_pop     = load && last_part;
      sel_in    = load ? !last_part : sel_ff;
      out_in    = out_ff;
      valid_in  = valid_ff && !rsp_pop;
      if (load) begin
         out_in   = sel_ff ? q_head.second : q_head.first;
         valid_in = 1'b1;
      end
      rsp_empty = !valid_ff;
      rsp_data  = out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

// ----- rtl/row_value_tlv_deserializer.sv -----
// Top level of the row/value TLV deserializer: parser front end, entry queue, output stage.
// Depends on rvtd_pkg, rvtd_front, rvtd_queue and rvtd_back.
//
//   channel   handshake            payload
//   req       req_push / req_full  req_data (data byte, frame marks, frame length)
//   rsp       rsp_pop / rsp_empty  rsp_data (kind, value, error code, offset, run end)
//   csr       csr_valid/csr_ready  csr_row_mode
//
// One byte is decoded per cycle in the front end; a beat enters whenever the queue is not full.
// A byte yields zero, one or two results; the output stage delivers one result per cycle while
// rsp_pop takes each result, so the two results of a two-result byte leave it one after the other.
// The first result of an accepted byte is written into the queue, then loaded into the output register.
// Reset is synchronous; it empties the queue and output register and sets row mode.
// A stalled rsp side fills the queue of QUEUE_DEPTH entries, after which req_full rises.
`timescale 1ns / 1ps

module row_value_tlv_deserializer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  rvtd_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output rvtd_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_row_mode
);

   logic                q_push, q_full, q_pop, q_empty;
   rvtd_pkg::entry_type q_in, q_head;

   assign csr_ready = 1'b1;
   assign req_full  = q_full;

   rvtd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_data     (req_data),
      .q_full       (q_full),
      .csr_valid    (csr_valid),
      .csr_row_mode (csr_row_mode),
      .q_push       (q_push),
      .q_entry      (q_in)
   );

   rvtd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head       (q_head)
   );

   rvtd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
